// ----- rtl/dode_pkg.sv -----
// Shared types and constants for the delta-of-delta timestamp encoder.
package dode_pkg;

	localparam int TS_W      = 64;
	localparam int BYTE_W    = 8;
	localparam int MAX_BYTES = 9;
	localparam int BUF_W     = MAX_BYTES * BYTE_W;
	localparam int CNT_W     = 4;

	// Signed limits of the short codes.
	localparam logic signed [TS_W-1:0] ONE_MIN   = -64'sd31;
	localparam logic signed [TS_W-1:0] ONE_MAX   = 64'sd31;
	localparam logic signed [TS_W-1:0] TWO_MIN   = -64'sd4095;
	localparam logic signed [TS_W-1:0] TWO_MAX   = 64'sd4095;
	localparam logic signed [TS_W-1:0] THREE_MIN = -64'sd524287;
	localparam logic signed [TS_W-1:0] THREE_MAX = 64'sd524286;

	// Code prefixes, already placed at the top of each code word.
	localparam logic [7:0]  PFX_ONE   = 8'h80;
	localparam logic [15:0] PFX_TWO   = 16'hC000;
	localparam logic [23:0] PFX_THREE = 24'hE00000;
	localparam logic [7:0]  PFX_ESC   = 8'h00;

	localparam logic [CNT_W-1:0] NB_ONE   = 4'd1;
	localparam logic [CNT_W-1:0] NB_TWO   = 4'd2;
	localparam logic [CNT_W-1:0] NB_THREE = 4'd3;
	localparam logic [CNT_W-1:0] NB_ESC   = 4'd9;

	typedef enum logic [1:0] {
		LEN_ONE,
		LEN_TWO,
		LEN_THREE,
		LEN_ESC
	} code_len_t;

endpackage

// ----- rtl/delta_of_delta_time_encoder.sv -----
// Delta-of-delta timestamp encoder: input register, code builder and byte serializer.
// Datapath: a timestamp transfer lands in the input register; its code is built from
// there and loaded into the byte serializer, whose top byte is presented on the output.
// Throughput: one output byte per cycle while m_tready is high; a code has 1, 2, 3 or 9
// bytes, set by its length; the first timestamp after reset is only stored and sends none.
// Reset (arst_n low, asynchronous) empties both stages and forgets the stored timestamp.
module delta_of_delta_time_encoder import dode_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [TS_W-1:0]   s_tdata,   // [63:0] timestamp
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
	output logic              m_tlast    // last_byte
);

	logic                    valid_s1;
	logic [TS_W-1:0]         ts_s1;
	logic                    seen_first_q;
	logic [TS_W-1:0]         prev_time_q;
	logic [TS_W-1:0]         prev_delta_q;
	logic [BUF_W-1:0]        buf_q;
	logic [CNT_W-1:0]        cnt_q;

	logic                    out_xfer;
	logic                    ser_free;
	logic                    load;
	logic signed [TS_W-1:0]  dod;
	code_len_t               len;
	logic [BUF_W-1:0]        code_buf;
	logic [CNT_W-1:0]        code_nb;

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = buf_q[BUF_W-1 -: BYTE_W];
	assign m_tlast  = (cnt_q == NB_ONE);
	assign out_xfer = m_tvalid && m_tready;

	// The serializer can take a new code when it is empty or its last byte leaves in this cycle.
	assign ser_free = (cnt_q == '0) || (m_tlast && m_tready);
	assign load     = valid_s1 && (!seen_first_q || ser_free);
	assign s_tready = !valid_s1 || load;

	assign dod = signed'(ts_s1 - prev_time_q - prev_delta_q);

	always_comb begin
		if (dod >= ONE_MIN && dod <= ONE_MAX) begin
			len = LEN_ONE;
		end else if (dod >= TWO_MIN && dod <= TWO_MAX) begin
			len = LEN_TWO;
		end else if (dod >= THREE_MIN && dod <= THREE_MAX) begin
			len = LEN_THREE;
		end else begin
			len = LEN_ESC;
		end
	end

	// Codes are left-justified in the buffer so the first byte sits on top.
	always_comb begin
		case (len)
			LEN_ONE: begin
				code_buf = {PFX_ONE | {2'b00, dod[5:0]}, {(BUF_W-8){1'b0}}};
				code_nb  = NB_ONE;
			end
			LEN_TWO: begin
				code_buf = {PFX_TWO | {3'b000, dod[12:0]}, {(BUF_W-16){1'b0}}};
				code_nb  = NB_TWO;
			end
			LEN_THREE: begin
				code_buf = {PFX_THREE | {4'b0000, dod[19:0]}, {(BUF_W-24){1'b0}}};
				code_nb  = NB_THREE;
			end
			default: begin
				code_buf = {PFX_ESC, dod};
				code_nb  = NB_ESC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ts_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_first_q <= 1'b0;
			prev_time_q  <= '0;
			prev_delta_q <= '0;
		end else if (load) begin
			seen_first_q <= 1'b1;
			prev_time_q  <= ts_s1;
			prev_delta_q <= seen_first_q ? dod : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load && seen_first_q) begin
			cnt_q <= code_nb;
		end else if (out_xfer) begin
			cnt_q <= cnt_q - NB_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (load && seen_first_q) begin
			buf_q <= code_buf;
		end else if (out_xfer) begin
			buf_q <= {buf_q[BUF_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
		end
	end

	// A loaded code always has one of the four legal lengths.
	assert property (@(posedge clk) disable iff (!arst_n)
		load && seen_first_q |=> cnt_q == NB_ONE || cnt_q == NB_TWO ||
			cnt_q == NB_THREE || cnt_q == NB_ESC)
		else $error("serializer loaded with an illegal byte count");

	// Nothing is sent before the first timestamp has been stored.
	assert property (@(posedge clk) disable iff (!arst_n)
		!seen_first_q |-> cnt_q == '0)
		else $error("output bytes before the first timestamp");

	// A waiting timestamp holds until the serializer takes it.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load |=> valid_s1 && $stable(ts_s1))
		else $error("input register lost a waiting timestamp");

	// A new code is never loaded over bytes that are still pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		load && seen_first_q |-> cnt_q == '0 || (cnt_q == NB_ONE && m_tready))
		else $error("code loaded over pending bytes");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the delta-of-delta timestamp encoder.
module testbench;
	import dode_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int N_EDGES = 12;
	localparam longint EDGE_DELTAS [N_EDGES] = '{
		31, -31, 32, -32, 4095, -4095, 4096, -4096,
		524286, -524287, 524287, -524288
	};

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic last;
	} code_byte_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [TS_W-1:0]   s_tdata;    // [63:0] timestamp
	logic              m_tvalid;
	logic              m_tready;
	logic [BYTE_W-1:0] m_tdata;    // [7:0] out_byte
	logic              m_tlast;    // last_byte

	// Expected encoder state, updated on every accepted timestamp.
	logic            have_first_ts;
	logic [TS_W-1:0] last_ts;
	logic [TS_W-1:0] last_dod;
	code_byte_t      pending_code_bytes [$];

	int error_count;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;

	delta_of_delta_time_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Work out the code bytes a timestamp must produce and queue them.
	function automatic void encode_timestamp(input logic [TS_W-1:0] ts);
		logic [TS_W-1:0]  dod;
		logic [BUF_W-1:0] word;
		code_len_t        len;
		int               nbytes;
		int               i;
		code_byte_t       cb;
		if (!have_first_ts) begin
			have_first_ts = 1'b1;
			last_ts = ts;
			last_dod = '0;
			return;
		end
		dod = (ts - last_ts) - last_dod;
		if ($signed(dod) >= -64'sd31 && $signed(dod) <= 64'sd31)
			len = LEN_ONE;
		else if ($signed(dod) >= -64'sd4095 && $signed(dod) <= 64'sd4095)
			len = LEN_TWO;
		else if ($signed(dod) >= -64'sd524287 && $signed(dod) <= 64'sd524286)
			len = LEN_THREE;
		else
			len = LEN_ESC;
		word = '0;
		case (len)
			LEN_ONE: begin
				word[7:0] = {2'b10, dod[5:0]};
				nbytes = 1;
			end
			LEN_TWO: begin
				word[15:0] = {3'b110, dod[12:0]};
				nbytes = 2;
			end
			LEN_THREE: begin
				word[23:0] = {4'b1110, dod[19:0]};
				nbytes = 3;
			end
			default: begin
				word = {8'h00, dod};
				nbytes = 9;
			end
		endcase
		for (i = nbytes - 1; i >= 0; i--) begin
			cb.data = word[8*i +: 8];
			cb.last = (i == 0);
			pending_code_bytes.push_back(cb);
		end
		last_dod = dod;
		last_ts = ts;
	endfunction

	// Handshakes are sampled at the falling edge; the transfer then happens at
	// the next rising edge, and all signals are stable in between.
	always @(negedge clk) begin
		code_byte_t exp_byte;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				encode_timestamp(s_tdata);
			if (m_tvalid && m_tready) begin
				if (pending_code_bytes.size() == 0) begin
					$error("unexpected output byte %02h (last %0b)", m_tdata, m_tlast);
					error_count++;
				end else begin
					exp_byte = pending_code_bytes.pop_front();
					if (m_tdata !== exp_byte.data) begin
						$error("out_byte mismatch: expected %02h, got %02h",
							exp_byte.data, m_tdata);
						error_count++;
					end
					if (m_tlast !== exp_byte.last) begin
						$error("last_byte mismatch: expected %0b, got %0b",
							exp_byte.last, m_tlast);
						error_count++;
					end
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Offer one timestamp, after a random gap, and return at its transfer edge.
	task automatic send_timestamp(input logic [TS_W-1:0] ts);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ts;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	// Send the timestamp that gives the wanted delta-of-delta.
	task automatic send_dod(input longint dod);
		logic [TS_W-1:0] ts;
		ts = last_ts + last_dod + dod;
		send_timestamp(ts);
	endtask

	function automatic longint pick_dod();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return longint'($urandom_range(62)) - 31;
		else if (r < 70)
			return longint'($urandom_range(8190)) - 4095;
		else if (r < 88)
			return longint'($urandom_range(1048573)) - 524287;
		else if (r < 94)
			return EDGE_DELTAS[$urandom_range(N_EDGES - 1)];
		else
			return longint'({$urandom, $urandom});
	endfunction

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending_code_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Code boundaries, both escape edges, and wrapping differences.
	task automatic test_directed_codes();
		int i;
		send_timestamp('1);    // first timestamp is only stored
		send_dod(0);
		for (i = 0; i < N_EDGES; i++)
			send_dod(EDGE_DELTAS[i]);
		send_dod(longint'(64'h8000_0000_0000_0000));
		send_dod(longint'(64'h7FFF_FFFF_FFFF_FFFF));
		send_timestamp('0);
		send_timestamp('1);
		send_timestamp(64'hAAAA_AAAA_AAAA_AAAA);
		send_timestamp(64'h5555_5555_5555_5555);
		send_dod(0);
		send_dod(-1);
		send_dod(1);
		wait_drain();
	endtask

	// Mostly well-formed timestamp series with a sprinkling of raw jumps.
	task automatic test_random_stream(input int n_items, input int s_idle, input int r_idle);
		int i;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (i = 0; i < n_items; i++) begin
			if ($urandom_range(99) < 10)
				send_timestamp({$urandom, $urandom});
			else
				send_dod(pick_dod());
		end
		wait_drain();
	endtask

	// The receiver stops for a long time while escape codes keep coming.
	task automatic test_output_backpressure();
		int i;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 400;
		for (i = 0; i < 24; i++) begin
			if (i % 3 == 0)
				send_dod(longint'({$urandom, $urandom}));
			else
				send_dod(pick_dod());
		end
		wait_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		have_first_ts = 1'b0;
		last_ts = '0;
		last_dod = '0;
		error_count = 0;
		cycle_count = 0;
		hold_left = 0;
		send_idle_pct = 28;
		recv_idle_pct = 60;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_codes();
		test_random_stream(150, 28, 60);
		test_random_stream(150, 60, 28);
		test_output_backpressure();
		test_random_stream(150, 0, 0);

		if (error_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
